@@ rtl/tqv_pkg.sv @@
// Shared types and request codes for the two-queue second-chance victim selector.
// Used by the controller, the datapath and the top level. No dependencies.
package tqv_pkg;

  typedef enum logic [2:0] {
    REQ_INSERT  = 3'd0,
    REQ_LOOKUP  = 3'd1,
    REQ_RELEASE = 3'd2,
    REQ_ERASE   = 3'd3,
    REQ_EVICT   = 3'd4
  } req_t;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_NO_VICTIM = 2'd1;
  localparam logic [1:0] ERR_COUNT     = 2'd2;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_SCAN,
    ST_LINK,
    ST_CLEAR,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic init_step;
    logic start;
    logic exec;
    logic scan_start;
    logic scan_step;
    logic clear_start;
    logic link;
    logic clear_step;
    logic swap;
    logic no_victim;
    logic take_victim;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic init_done;
    logic is_evict;
    logic scan_done;
    logic clear_done;
    logic last_swap;
    logic prefix_nonzero;
    logic link_needed;
  } stat_t;

endpackage

@@ rtl/tqv_ctrl.sv @@
// Controller state machine of the victim selector.
// Depends on tqv_pkg for the state, command and status types.
module tqv_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  tqv_pkg::stat_t  stat,
  output tqv_pkg::cmd_t   cmd
);

  tqv_pkg::state_t state, state_next;
  logic clear_swap, clear_swap_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tqv_pkg::ST_INIT;
      clear_swap <= 1'b0;
    end else begin
      state <= state_next;
      clear_swap <= clear_swap_next;
    end
  end

  always_comb begin
    state_next = state;
    clear_swap_next = clear_swap;
    unique case (state)
      tqv_pkg::ST_INIT: if (stat.init_done) state_next = tqv_pkg::ST_IDLE;
      tqv_pkg::ST_IDLE: if (in_valid) state_next = tqv_pkg::ST_READ;
      tqv_pkg::ST_READ: begin
        if (stat.is_evict) state_next = tqv_pkg::ST_SCAN;
        else state_next = tqv_pkg::ST_EXEC;
      end
      tqv_pkg::ST_EXEC: state_next = tqv_pkg::ST_OUT;
      tqv_pkg::ST_SCAN: begin
        if (stat.scan_done) begin
          state_next = tqv_pkg::ST_CLEAR;
          clear_swap_next = !stat.link_needed;
        end
      end
      tqv_pkg::ST_CLEAR: begin
        if (stat.clear_done) begin
          if (clear_swap) begin
            if (stat.last_swap) state_next = tqv_pkg::ST_OUT;
            else state_next = tqv_pkg::ST_READ;
          end else begin
            state_next = tqv_pkg::ST_LINK;
          end
        end
      end
      tqv_pkg::ST_LINK: state_next = tqv_pkg::ST_OUT;
      tqv_pkg::ST_OUT: if (out_ready) state_next = tqv_pkg::ST_IDLE;
      default: state_next = tqv_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      tqv_pkg::ST_INIT: cmd.init_step = 1'b1;
      tqv_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.start = in_valid;
      end
      tqv_pkg::ST_READ: cmd.scan_start = stat.is_evict;
      tqv_pkg::ST_EXEC: cmd.exec = 1'b1;
      tqv_pkg::ST_SCAN: begin
        cmd.scan_step = !stat.scan_done;
        cmd.clear_start = stat.scan_done;
        cmd.take_victim = stat.scan_done && stat.link_needed;
      end
      tqv_pkg::ST_CLEAR: begin
        cmd.clear_step = !stat.clear_done;
        if (stat.clear_done && clear_swap) begin
          cmd.swap = 1'b1;
          cmd.no_victim = stat.last_swap;
        end
      end
      tqv_pkg::ST_LINK: cmd.link = stat.prefix_nonzero;
      tqv_pkg::ST_OUT: out_valid = 1'b1;
      default: ;
    endcase
  end

endmodule

@@ rtl/tqv_dp.sv @@
// Datapath of the victim selector: link memory, queue registers, flags and counts.
// Depends on tqv_pkg for request codes and the command and status types.
module tqv_dp #(
  parameter int SLOTS = 64,
  parameter int REF_BITS = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [2:0]     req_type,
  input  logic [5:0]     slot,
  input  logic           pin,
  input  tqv_pkg::cmd_t  cmd,
  output tqv_pkg::stat_t stat,
  output logic [5:0]     victim_slot,
  output logic           victim_valid,
  output logic           last_release,
  output logic [1:0]     error
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [REF_BITS-1:0] REF_MAX = '1;

  logic [AW-1:0] link_mem [SLOTS];
  logic [REF_BITS-1:0] cnt_mem [SLOTS];
  logic cached_mem [SLOTS];
  logic hit_mem [SLOTS];

  logic [AW-1:0] link_q;
  logic [REF_BITS-1:0] cnt_q;
  logic cached_q;
  logic hit_q;
  logic [AW-1:0] rd_addr;

  logic [AW-1:0] queue_head [2];
  logic [AW-1:0] queue_tail [2];
  logic [CW-1:0] queue_count [2];
  logic active_queue;

  logic [2:0] req;
  logic [AW-1:0] s;
  logic s_ok;
  logic pin_r;
  logic [AW-1:0] curr, prev, first, walk, init_i;
  logic [CW-1:0] k, clr_i;
  logic [1:0] swaps;

  logic [CW-1:0] n_act;
  logic skip_curr;
  logic room;

  assign n_act = queue_count[active_queue];
  assign skip_curr = (cached_q && hit_q) || (cnt_q != '0);
  assign room = (queue_count[0] + queue_count[1]) < CW'(SLOTS);

  always_comb begin
    stat = '0;
    stat.init_done = (init_i == AW'(SLOTS - 1));
    stat.is_evict = (req == tqv_pkg::REQ_EVICT);
    stat.scan_done = (n_act == '0) || (k + CW'(1) >= n_act) || !skip_curr;
    stat.link_needed = (n_act != '0) && (k + CW'(1) < n_act);
    stat.clear_done = (clr_i >= k);
    stat.last_swap = (swaps == 2'd2);
    stat.prefix_nonzero = (k != '0);
  end

  always_comb begin
    rd_addr = s;
    if (cmd.scan_start) rd_addr = queue_head[active_queue];
    else if (cmd.scan_step || cmd.clear_step) rd_addr = link_q;
    else if (cmd.clear_start) rd_addr = first;
  end

  always_ff @(posedge clk) begin
    link_q <= link_mem[rd_addr];
    cnt_q <= cnt_mem[rd_addr];
    cached_q <= cached_mem[rd_addr];
    hit_q <= hit_mem[rd_addr];
    if (cmd.init_step) begin
      cnt_mem[init_i] <= '0;
      cached_mem[init_i] <= 1'b0;
      hit_mem[init_i] <= 1'b0;
    end
    if (cmd.exec && s_ok) begin
      unique case (req)
        tqv_pkg::REQ_INSERT: begin
          cached_mem[s] <= 1'b1;
          hit_mem[s] <= 1'b0;
          cnt_mem[s] <= REF_BITS'(pin_r);
          if (room && n_act != '0) link_mem[queue_tail[active_queue]] <= s;
        end
        tqv_pkg::REQ_LOOKUP: begin
          if (cnt_q < REF_MAX) begin
            cnt_mem[s] <= cnt_q + REF_BITS'(1);
            hit_mem[s] <= 1'b1;
          end
        end
        tqv_pkg::REQ_RELEASE: begin
          if (cnt_q != '0) cnt_mem[s] <= cnt_q - REF_BITS'(1);
        end
        tqv_pkg::REQ_ERASE: cached_mem[s] <= 1'b0;
        default: ;
      endcase
    end
    if (cmd.clear_step) hit_mem[walk] <= 1'b0;
    if (cmd.link && queue_count[!active_queue] != '0)
      link_mem[queue_tail[!active_queue]] <= first;
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req <= req_type;
      s <= AW'(slot);
      s_ok <= ({26'd0, slot} < 32'(SLOTS));
      pin_r <= pin;
      victim_slot <= '0;
      victim_valid <= 1'b0;
      last_release <= 1'b0;
      error <= tqv_pkg::ERR_NONE;
      swaps <= '0;
    end
    if (cmd.scan_start) begin
      curr <= queue_head[active_queue];
      prev <= queue_head[active_queue];
      first <= queue_head[active_queue];
      k <= '0;
    end
    if (cmd.scan_step) begin
      prev <= curr;
      curr <= link_q;
      k <= k + CW'(1);
    end
    if (cmd.exec && s_ok) begin
      if (req == tqv_pkg::REQ_LOOKUP) begin
        if (cnt_q >= REF_MAX) error <= tqv_pkg::ERR_COUNT;
      end else if (req == tqv_pkg::REQ_RELEASE) begin
        if (cnt_q == '0) error <= tqv_pkg::ERR_COUNT;
        else if (cnt_q == REF_BITS'(1) && cached_q) last_release <= 1'b1;
      end
    end
    if (cmd.take_victim) begin
      victim_slot <= 6'(curr);
      victim_valid <= 1'b1;
    end
    if (cmd.clear_start) begin
      walk <= first;
      clr_i <= '0;
    end
    if (cmd.clear_step) begin
      walk <= link_q;
      clr_i <= clr_i + CW'(1);
    end
    if (cmd.swap) begin
      swaps <= swaps + 2'd1;
      if (cmd.no_victim) error <= tqv_pkg::ERR_NO_VICTIM;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_head[0] <= '0;
      queue_head[1] <= '0;
      queue_tail[0] <= '0;
      queue_tail[1] <= '0;
      queue_count[0] <= '0;
      queue_count[1] <= '0;
      active_queue <= 1'b0;
      init_i <= '0;
    end else begin
      if (cmd.init_step) init_i <= init_i + AW'(1);
      if (cmd.exec && s_ok && req == tqv_pkg::REQ_INSERT && room) begin
        if (n_act == '0) queue_head[active_queue] <= s;
        queue_tail[active_queue] <= s;
        queue_count[active_queue] <= n_act + CW'(1);
      end
      if (cmd.swap) active_queue <= !active_queue;
      if (cmd.take_victim) begin
        queue_head[active_queue] <= link_q;
        queue_count[active_queue] <= n_act - (k + CW'(1));
      end
      if (cmd.link) begin
        if (queue_count[!active_queue] == '0) queue_head[!active_queue] <= first;
        queue_tail[!active_queue] <= prev;
        queue_count[!active_queue] <= queue_count[!active_queue] + k;
      end
    end
  end

endmodule

@@ rtl/two_queue_second_chance_victim.sv @@
// Top level of the two-queue second-chance victim selector.
// Depends on tqv_pkg, tqv_ctrl and tqv_dp.
//
// One request word enters on the in channel (req_type, slot, pin) and one
// result word leaves on the out channel. Both channels use valid/ready.
// One request is in flight at a time; in_ready is low until the result
// word has been taken.
// Insert, lookup, release and erase pass through the READ and EXEC states
// and raise out_valid in the OUT state.
// An evict walks the active queue one entry per cycle and then clears the
// hit bits of the skipped prefix one entry per cycle; such a pass is
// repeated after a queue swap, at most three passes. A found victim then
// has the prefix moved to the dormant queue in the LINK state. The walk
// over the link memory sets the rate.
// After reset a clearing pass over all SLOTS slots (64 by default) zeroes the
// flags and counts of every slot with in_ready low; both queues start empty.
// A stalled receiver holds the result word unchanged.
module two_queue_second_chance_victim #(
  parameter int SLOTS = 64,
  parameter int REF_BITS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] req_type,
  input  logic [5:0] slot,
  input  logic       pin,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [5:0] victim_slot,
  output logic       victim_valid,
  output logic       last_release,
  output logic [1:0] error
);

  tqv_pkg::cmd_t cmd;
  tqv_pkg::stat_t stat;

  tqv_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .stat, .cmd
  );

  tqv_dp #(.SLOTS(SLOTS), .REF_BITS(REF_BITS)) u_dp (
    .clk, .rst, .req_type, .slot, .pin, .cmd, .stat,
    .victim_slot, .victim_valid, .last_release, .error
  );

  a_excl : assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("in_ready and out_valid both high");
  a_vic : assert property (@(posedge clk) disable iff (rst)
    out_valid && victim_valid |-> error == tqv_pkg::ERR_NONE)
    else $error("victim with error");
  a_hold : assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(victim_slot) && $stable(error))
    else $error("result changed under stall");

endmodule
